>>> src/mrx_pkg.sv
`default_nettype none
package mrx_pkg;

    // Function codes of the R-type instructions.
    localparam logic [5:0] FN_SLL   = 6'd0;
    localparam logic [5:0] FN_SRL   = 6'd2;
    localparam logic [5:0] FN_SRA   = 6'd3;
    localparam logic [5:0] FN_SLLV  = 6'd4;
    localparam logic [5:0] FN_SRLV  = 6'd6;
    localparam logic [5:0] FN_SRAV  = 6'd7;
    localparam logic [5:0] FN_JR    = 6'd8;
    localparam logic [5:0] FN_JALR  = 6'd9;
    localparam logic [5:0] FN_MFHI  = 6'd16;
    localparam logic [5:0] FN_MTHI  = 6'd17;
    localparam logic [5:0] FN_MFLO  = 6'd18;
    localparam logic [5:0] FN_MTLO  = 6'd19;
    localparam logic [5:0] FN_MULT  = 6'd24;
    localparam logic [5:0] FN_MULTU = 6'd25;
    localparam logic [5:0] FN_DIV   = 6'd26;
    localparam logic [5:0] FN_DIVU  = 6'd27;
    localparam logic [5:0] FN_ADD   = 6'd32;
    localparam logic [5:0] FN_ADDU  = 6'd33;
    localparam logic [5:0] FN_SUB   = 6'd34;
    localparam logic [5:0] FN_SUBU  = 6'd35;
    localparam logic [5:0] FN_AND   = 6'd36;
    localparam logic [5:0] FN_OR    = 6'd37;
    localparam logic [5:0] FN_XOR   = 6'd38;
    localparam logic [5:0] FN_SLT   = 6'd42;
    localparam logic [5:0] FN_SLTU  = 6'd43;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;
    localparam logic [1:0] ST_UNK  = 2'd3;

    // Operation classes chosen by the front end.
    typedef enum logic [3:0] {
        OP_ADD, OP_ADDU, OP_SUB, OP_SUBU, OP_LOGIC, OP_SLT, OP_SHIFT,
        OP_MUL, OP_DIV, OP_MFHL, OP_MTHL, OP_JUMP, OP_UNK
    } t_op;

    // Decoded item handed from front to back.
    typedef struct packed {
        t_op         op;
        logic [5:0]  fn;
        logic [4:0]  rd;
        logic [4:0]  shamt;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc;
    } t_dec;

    localparam int DEC_W = $bits(t_dec);

    // Queue depth between front and back.
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // Back-end sequencer states.
    typedef enum logic [1:0] {S_IDLE, S_ITER, S_FIX, S_DONE} t_state;

endpackage
`default_nettype wire

>>> src/mrx_if.sv
`default_nettype none
interface mrx_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [31:0] current_pc;
    modport source (output valid, instruction_word, rs_value, rt_value, current_pc,
                    input ready);
    modport sink   (input valid, instruction_word, rs_value, rt_value, current_pc,
                    output ready);
endinterface

interface mrx_out_if;
    logic        valid;
    logic        ready;
    logic        reg_write;
    logic [4:0]  dest_index;
    logic [31:0] write_data;
    logic        jump_taken;
    logic [31:0] jump_target;
    logic [1:0]  status;
    modport source (output valid, reg_write, dest_index, write_data, jump_taken,
                    jump_target, status, input ready);
    modport sink   (input valid, reg_write, dest_index, write_data, jump_taken,
                    jump_target, status, output ready);
endinterface
`default_nettype wire

>>> src/mrx_front.sv
`default_nettype none
module mrx_front
    import mrx_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrx_in_if.sink     i_in,
    output t_dec       o_dec,
    output logic       o_dec_valid,
    input  wire logic  i_dec_ready
);

    logic [5:0] fn;
    t_op        op;

    assign fn = i_in.instruction_word[5:0];

    // Classify the function code.
    always_comb begin
        unique case (fn)
            FN_ADD:  op = OP_ADD;
            FN_ADDU: op = OP_ADDU;
            FN_SUB:  op = OP_SUB;
            FN_SUBU: op = OP_SUBU;
            FN_AND, FN_OR, FN_XOR: op = OP_LOGIC;
            FN_SLT, FN_SLTU: op = OP_SLT;
            FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV: op = OP_SHIFT;
            FN_MULT, FN_MULTU: op = OP_MUL;
            FN_DIV, FN_DIVU: op = OP_DIV;
            FN_MFHI, FN_MFLO: op = OP_MFHL;
            FN_MTHI, FN_MTLO: op = OP_MTHL;
            FN_JR, FN_JALR: op = OP_JUMP;
            default: op = OP_UNK;
        endcase
    end

    // Small queue of decoded items.
    t_dec           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           push, pop;

    assign i_in.ready  = (r_cnt != (QAW+1)'(QDEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign o_dec_valid = (r_cnt != '0);
    assign pop         = o_dec_valid && i_dec_ready;
    assign o_dec       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{op: op, fn: fn, rd: i_in.instruction_word[15:11],
                             shamt: i_in.instruction_word[10:6],
                             a: i_in.rs_value, b: i_in.rt_value,
                             pc: i_in.current_pc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not advance");

endmodule
`default_nettype wire

>>> src/mrx_back.sv
`default_nettype none
module mrx_back
    import mrx_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_dec  i_dec,
    input  wire logic  i_dec_valid,
    output logic       o_dec_ready,
    mrx_out_if.source  o_out
);

    t_state r_state, n_state;
    t_dec   r_it;
    logic [31:0] r_hi, r_lo;
    logic [5:0]  r_cnt;
    // Shared shift-add / shift-subtract datapath.
    logic [31:0] r_acc, r_q, r_m;
    logic        r_na, r_nb;
    logic        r_ov, r_wr, r_jmp;
    logic [4:0]  r_rd;
    logic [31:0] r_data, r_tgt;
    logic [1:0]  r_st;

    logic        take, deliver, is_div, is_signed, last;
    logic [31:0] a, b, ma, mb;
    logic [32:0] sum, trial;

    assign o_dec_ready = (r_state == S_IDLE);
    assign take        = i_dec_valid && o_dec_ready;
    assign deliver     = o_out.valid && o_out.ready;
    assign a           = i_dec.a;
    assign b           = i_dec.b;
    assign is_signed   = !r_it.fn[0];
    assign is_div      = (r_it.op == OP_DIV);
    assign last        = (r_cnt == 6'd31);
    assign ma          = (i_dec.fn[0] == 1'b0 && a[31]) ? (32'd0 - a) : a;
    assign mb          = (i_dec.fn[0] == 1'b0 && b[31]) ? (32'd0 - b) : b;

    // One multiply step adds the multiplicand when the low multiplier bit is set; one divide step trial-subtracts.
    assign sum   = {1'b0, r_acc} + (r_q[0] ? {1'b0, r_m} : 33'd0);
    assign trial = {r_acc[31:0], r_q[31]} - {1'b0, r_m};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (take) n_state = ((i_dec.op == OP_MUL ||
                                         (i_dec.op == OP_DIV && b != 32'd0)) ?
                                        S_ITER : S_DONE);
            S_ITER: if (last) n_state = S_FIX;
            S_FIX:  n_state = S_DONE;
            S_DONE: if (deliver) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Output side of the sequencer.
    always_comb begin
        o_out.valid       = (r_state == S_DONE);
        o_out.reg_write   = r_wr;
        o_out.dest_index  = r_wr ? r_rd : 5'd0;
        o_out.write_data  = r_wr ? r_data : 32'd0;
        o_out.jump_taken  = r_jmp;
        o_out.jump_target = r_jmp ? r_tgt : 32'd0;
        o_out.status      = r_st;
    end

    // Results computed combinationally at issue for the operations that need no iteration.
    logic        c_wr, c_jmp;
    logic [31:0] c_data;
    logic [1:0]  c_st;
    logic [31:0] addr, subr;
    logic [4:0]  sh;
    always_comb begin
        addr   = a + b;
        subr   = a - b;
        sh     = i_dec.fn[2] ? a[4:0] : i_dec.shamt;
        c_wr   = 1'b1;
        c_jmp  = 1'b0;
        c_data = 32'd0;
        c_st   = ST_OK;
        unique case (i_dec.op)
            OP_ADD: begin
                c_data = addr;
                if (~(a[31] ^ b[31]) & (a[31] ^ addr[31])) begin
                    c_st = ST_OVF; c_wr = 1'b0;
                end
            end
            OP_ADDU: c_data = addr;
            OP_SUB: begin
                c_data = subr;
                if ((a[31] ^ b[31]) & (a[31] ^ subr[31])) begin
                    c_st = ST_OVF; c_wr = 1'b0;
                end
            end
            OP_SUBU: c_data = subr;
            OP_LOGIC: begin
                case (i_dec.fn)
                    FN_AND:  c_data = a & b;
                    FN_OR:   c_data = a | b;
                    default: c_data = a ^ b;
                endcase
            end
            OP_SLT: c_data = (i_dec.fn == FN_SLT) ?
                             {31'd0, $signed(a) < $signed(b)} : {31'd0, a < b};
            OP_SHIFT: begin
                case (i_dec.fn[1:0])
                    2'd0:    c_data = b << sh;
                    2'd2:    c_data = b >> sh;
                    default: c_data = 32'($signed(b) >>> sh);
                endcase
            end
            OP_MUL: c_wr = 1'b0;
            OP_DIV: begin
                c_wr = 1'b0;
                if (b == 32'd0) c_st = ST_DIVZ;
            end
            OP_MFHL: c_data = (i_dec.fn == FN_MFHI) ? r_hi : r_lo;
            OP_MTHL: c_wr = 1'b0;
            OP_JUMP: begin
                c_jmp  = 1'b1;
                c_wr   = (i_dec.fn == FN_JALR);
                c_data = i_dec.pc + 32'd8;
            end
            default: begin
                c_wr = 1'b0;
                c_st = ST_UNK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hi    <= '0;
            r_lo    <= '0;
        end else begin
            r_state <= n_state;
            if (take && i_dec.op == OP_MTHL) begin
                if (i_dec.fn == FN_MTHI) r_hi <= a;
                else r_lo <= a;
            end
            if (r_state == S_FIX) begin
                if (is_div) begin
                    r_lo <= (is_signed && (r_na != r_nb)) ? 32'd0 - r_q : r_q;
                    r_hi <= (is_signed && r_na) ? 32'd0 - r_acc : r_acc;
                end else if (is_signed && r_ov) begin
                    {r_hi, r_lo} <= 64'd0 - {r_acc, r_q};
                end else begin
                    {r_hi, r_lo} <= {r_acc, r_q};
                end
            end
        end
    end

    // Payload and iteration registers.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_it   <= i_dec;
            r_rd   <= i_dec.rd;
            r_wr   <= c_wr;
            r_jmp  <= c_jmp;
            r_tgt  <= a;
            r_data <= c_data;
            r_st   <= c_st;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_q    <= ma;
            r_m    <= mb;
            r_na   <= a[31];
            r_nb   <= b[31];
            r_ov   <= (a[31] ^ b[31]) & !i_dec.fn[0];
        end else if (r_state == S_ITER) begin
            r_cnt <= r_cnt + 6'd1;
            if (is_div) begin
                if (!trial[32]) begin
                    r_acc <= trial[31:0];
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_acc <= {r_acc[30:0], r_q[31]};
                    r_q   <= {r_q[30:0], 1'b0};
                end
            end else begin
                r_acc <= sum[32:1];
                r_q   <= {sum[0], r_q[31:1]};
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !o_out.ready) |=> (r_state == S_DONE && $stable(r_data)))
        else $error("result changed while held");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER && last) |=> (r_state == S_FIX))
        else $error("iteration did not end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_dec.op == OP_DIV && i_dec.b == 32'd0) |=> $stable(r_hi) && $stable(r_lo))
        else $error("divide by zero touched HI/LO");

endmodule
`default_nettype wire

>>> src/mips_rtype_execute_unit_top.sv
`default_nettype none
// From accept to result, simple operations pass the queue stage and then the
// execute register; multiply, and divide by a nonzero value, also pass the
// 32 steps of the shared shift-add/shift-subtract unit and a fix-up state.
// The back end takes a new item only after its previous result is delivered.
// Reset (synchronous, active low) empties the queue and clears HI and LO.
module mips_rtype_execute_unit_top
    import mrx_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mrx_in_if.sink    i_in,
    mrx_out_if.source o_out
);

    t_dec dec;
    logic dec_valid, dec_ready;

    mrx_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_dec(dec), .o_dec_valid(dec_valid), .i_dec_ready(dec_ready)
    );

    mrx_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_dec(dec), .i_dec_valid(dec_valid), .o_dec_ready(dec_ready),
        .o_out(o_out)
    );

endmodule
`default_nettype wire
